// ===== rtl/deq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Deque package
// Shared types and constants for the double-ended queue and its ring memory.
// ----------------------------------------------------------------------------
package deq_pkg;

    // Word and result field widths
    localparam int DATA_W      = 32;
    localparam int COUNT_OUT_W = 5;
    localparam int FUNC_W      = 2;

    // Default ring depth
    localparam int DEPTH_DEF = 16;

    // Stream payload widths, padded to whole bytes
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 72;

    // Operation codes
    typedef enum logic [FUNC_W-1:0] {
        FUNC_PUSH_FRONT = 2'd0,
        FUNC_PUSH_BACK  = 2'd1,
        FUNC_POP_FRONT  = 2'd2,
        FUNC_POP_BACK   = 2'd3
    } t_func;

    // Sequencer states
    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_LOAD
    } t_state;

endpackage

// ===== rtl/deq_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Deque ring memory
// One write port and two registered read ports for the front and back words.
// ----------------------------------------------------------------------------
module deq_ram
    import deq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [AW-1:0]     i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic [AW-1:0]     i_raddr_a,
    input  logic [AW-1:0]     i_raddr_b,
    output logic [DATA_W-1:0] o_rdata_a,
    output logic [DATA_W-1:0] o_rdata_b
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata_a;
    logic [DATA_W-1:0] r_rdata_b;

    // Write one word
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read both ports through output registers
    always_ff @(posedge i_clk) begin
        r_rdata_a <= r_mem[i_raddr_a];
        r_rdata_b <= r_mem[i_raddr_b];
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

// ===== rtl/double_ended_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Double-ended queue
// Ring-buffer deque of signed 32-bit words with front and back push and pop.
// ----------------------------------------------------------------------------
// Each item passes through an accept, a read and a load step: the accept step
// updates the front pointer and count and writes a pushed word into the ring
// memory, the next cycle reads the new front and back entries from the memory,
// and the load step fills the result register from that read. A result
// that waits on the output holds the block in its load step, and the next
// item is taken once the result register is free. A pop on an empty deque or
// a push on a full deque is refused (accepted = 0) and changes nothing; front
// and back values read zero while the deque is empty. entry_count carries the
// low five bits of the count. No clearing pass runs after reset.
// ----------------------------------------------------------------------------
module double_ended_queue
    import deq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // Input items
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    // [1:0] func, [33:2] push_value, [39:34] zero
    input  logic [IN_TDATA_W-1:0]  i_s_axis_tdata,
    // Result items
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    // [0] accepted, [1] is_empty, [6:2] entry_count, [38:7] front_value,
    // [70:39] back_value, [71] zero
    output logic [OUT_TDATA_W-1:0] o_m_axis_tdata
);

    localparam int AW  = $clog2(DEPTH);
    localparam int CW  = $clog2(DEPTH + 1);
    localparam int SW  = AW + 1;
    localparam int CXW = (CW > COUNT_OUT_W) ? CW : COUNT_OUT_W;

    // Control state
    t_state             r_state, n_state;
    logic [AW-1:0]      r_front, n_front;
    logic [CW-1:0]      r_count, n_count;
    logic               r_acc, n_acc;
    logic               r_m_valid, n_m_valid;
    // Result payload
    logic [OUT_TDATA_W-1:0] r_m_data, n_m_data;

    // Input decode
    t_func              in_func;
    logic [DATA_W-1:0]  in_value;
    logic               in_accept;
    logic               is_push;
    logic               is_full;
    logic               is_empty;

    // Ring addressing
    logic [AW-1:0]      front_dec;
    logic [AW-1:0]      front_inc;
    logic [SW-1:0]      tail_sum;
    logic [AW-1:0]      tail_addr;
    logic [SW-1:0]      back_sum;
    logic [AW-1:0]      back_addr;

    // Memory ports
    logic               mem_we;
    logic [AW-1:0]      mem_waddr;
    logic [DATA_W-1:0]  front_rdata;
    logic [DATA_W-1:0]  back_rdata;

    // Result fields
    logic [CXW-1:0]         count_ext;
    logic [COUNT_OUT_W-1:0] count_out;
    logic [DATA_W-1:0]      front_out;
    logic [DATA_W-1:0]      back_out;

    assign in_func   = t_func'(i_s_axis_tdata[FUNC_W-1:0]);
    assign in_value  = i_s_axis_tdata[FUNC_W +: DATA_W];
    assign in_accept = i_s_axis_tvalid && o_s_axis_tready;
    assign is_push   = (in_func == FUNC_PUSH_FRONT) || (in_func == FUNC_PUSH_BACK);
    assign is_full   = (r_count == CW'(DEPTH));
    assign is_empty  = (r_count == '0);

    // Step the front pointer around the ring
    assign front_dec = (r_front == '0) ? AW'(DEPTH - 1) : r_front - AW'(1);
    assign front_inc = (r_front == AW'(DEPTH - 1)) ? '0 : r_front + AW'(1);

    // Slot after the back entry, for a push at the back
    assign tail_sum  = SW'(r_front) + SW'(r_count);
    assign tail_addr = (tail_sum >= SW'(DEPTH)) ? AW'(tail_sum - SW'(DEPTH))
                                                : AW'(tail_sum);

    // Back entry; only used while the deque is not empty
    assign back_sum  = SW'(r_front) + SW'(r_count) - SW'(1);
    assign back_addr = (back_sum >= SW'(DEPTH)) ? AW'(back_sum - SW'(DEPTH))
                                                : AW'(back_sum);

    // Write a pushed word when there is room
    assign mem_we    = in_accept && is_push && !is_full;
    assign mem_waddr = (in_func == FUNC_PUSH_FRONT) ? front_dec : tail_addr;

    deq_ram #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ram (
        .i_clk     (i_clk),
        .i_we      (mem_we),
        .i_waddr   (mem_waddr),
        .i_wdata   (in_value),
        .i_raddr_a (r_front),
        .i_raddr_b (back_addr),
        .o_rdata_a (front_rdata),
        .o_rdata_b (back_rdata)
    );

    // Form result fields
    assign count_ext = CXW'(r_count);
    assign count_out = count_ext[COUNT_OUT_W-1:0];
    assign front_out = is_empty ? '0 : front_rdata;
    assign back_out  = is_empty ? '0 : back_rdata;

    // Register state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_front   <= '0;
            r_count   <= '0;
            r_acc     <= 1'b0;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_front   <= n_front;
            r_count   <= n_count;
            r_acc     <= n_acc;
            r_m_valid <= n_m_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_m_data <= n_m_data;
    end

    // Sequence one item: update pointers, read the ring, load the result
    always_comb begin
        n_state   = r_state;
        n_front   = r_front;
        n_count   = r_count;
        n_acc     = r_acc;
        n_m_valid = r_m_valid;
        n_m_data  = r_m_data;

        // Drop the result once taken
        if (r_m_valid && i_m_axis_tready) begin
            n_m_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    n_state = S_READ;
                    n_acc   = 1'b0;
                    unique case (in_func)
                        FUNC_PUSH_FRONT: begin
                            if (!is_full) begin
                                n_front = front_dec;
                                n_count = r_count + CW'(1);
                                n_acc   = 1'b1;
                            end
                        end
                        FUNC_PUSH_BACK: begin
                            if (!is_full) begin
                                n_count = r_count + CW'(1);
                                n_acc   = 1'b1;
                            end
                        end
                        FUNC_POP_FRONT: begin
                            if (!is_empty) begin
                                n_front = front_inc;
                                n_count = r_count - CW'(1);
                                n_acc   = 1'b1;
                            end
                        end
                        FUNC_POP_BACK: begin
                            if (!is_empty) begin
                                n_count = r_count - CW'(1);
                                n_acc   = 1'b1;
                            end
                        end
                        default: begin
                            n_acc = 1'b0;
                        end
                    endcase
                end
            end
            S_READ: begin
                n_state = S_LOAD;
            end
            S_LOAD: begin
                // Hold until the result register is free
                if (!r_m_valid || i_m_axis_tready) begin
                    n_m_valid = 1'b1;
                    n_m_data  = {1'b0, back_out, front_out, count_out, is_empty, r_acc};
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_m_valid;
    assign o_m_axis_tdata  = r_m_data;

    // Count stays within the ring
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("deque count above depth");

    // Front pointer stays within the ring
    a_front_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_front <= AW'(DEPTH - 1))
        else $error("front pointer outside ring");

    // A push into a full deque is refused and leaves the count
    a_full_refuse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && is_push && is_full) |=> (!r_acc && r_count == CW'(DEPTH)))
        else $error("push into full deque was taken");

    // A pop from an empty deque is refused and leaves the count
    a_empty_refuse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && !is_push && is_empty) |=> (!r_acc && r_count == '0))
        else $error("pop from empty deque was taken");

    // Pointer and count hold while the ring is being read
    a_hold_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ) |=> ($stable(r_front) && $stable(r_count)))
        else $error("pointer moved during ring read");

endmodule
